/* hdl/pstb_pkg.sv */
package pstb_pkg;

  // Field widths
  localparam int unsigned KeyW  = 64;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CostW = 16;
  localparam int unsigned TokW  = 24;
  localparam int unsigned RateW = 20;

  // Stream payload widths
  localparam int unsigned InW  = KeyW + TimeW + CostW;  // 112 bits, 14 bytes
  localparam int unsigned OutW = 32;                    // 26 bits of fields, zero filled

  // One table entry: {last_time, tokens, key}
  localparam int unsigned EntW = KeyW + TokW + TimeW;

  // Refill arithmetic: rate * elapsed, then divide by ms per second.
  // Any gain of 2^24 or more fills the bucket to the cap, so only products
  // below 1000 * 2^24 (34 bits) need an exact quotient. Divide by 8 with a
  // shift, then by 125 with a reciprocal multiply, exact for 31-bit inputs.
  localparam int unsigned ProdW      = RateW + TimeW;
  localparam int unsigned RecipInW   = 31;
  localparam int unsigned RecipW     = 32;
  localparam int unsigned RecipProdW = RecipInW + RecipW;
  localparam int unsigned RecipShift = 38;
  localparam logic [RecipW-1:0] Recip125    = 32'd2199023256;  // ceil(2^38 / 125)
  localparam logic [ProdW-1:0]  GainSatProd = ProdW'(64'd1000 << TokW);
  localparam logic [ProdW-1:0]  GainSat     = ProdW'(64'd1 << TokW);

  // Configuration register map (index = paddr[2])
  localparam logic RegRefillRate = 1'b0;
  localparam logic RegBurstCap   = 1'b1;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [RateW-1:0] RefillRateRst = RateW'(100);
  localparam logic [TokW-1:0]  BurstCapRst   = TokW'(200);

  typedef struct packed {
    logic             start;
    logic [RateW-1:0] rate;
    logic [TimeW-1:0] elapsed;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [ProdW-1:0] gain;
  } div_rsp_t;

endpackage

/* hdl/pstb_ram.sv */
module pstb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/pstb_div.sv */
module pstb_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pstb_pkg::div_req_t  req_i,
  output pstb_pkg::div_rsp_t  rsp_o
);
  import pstb_pkg::*;

  logic                  mul_vld_q;
  logic                  done_q;
  logic [ProdW-1:0]      prod;
  logic [ProdW-1:0]      prod_q;
  logic [ProdW-1:0]      gain_q;
  logic [ProdW-1:0]      gain_d;
  logic                  sat;
  logic [RecipInW-1:0]   recip_in;
  logic [RecipProdW-1:0] recip_prod;

  // first stage: rate times elapsed
  assign prod = ProdW'(req_i.rate) * ProdW'(req_i.elapsed);

  // second stage: saturate large gains, else drop 3 bits and multiply by 1/125
  assign sat        = (prod_q >= GainSatProd);
  assign recip_in   = prod_q[RecipInW+2:3];
  assign recip_prod = RecipProdW'(recip_in) * RecipProdW'(Recip125);
  assign gain_d     = sat ? GainSat : ProdW'(recip_prod[RecipProdW-1:RecipShift]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      mul_vld_q <= req_i.start;
      done_q    <= mul_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      prod_q <= prod;
    end
    if (mul_vld_q) begin
      gain_q <= gain_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.gain = gain_q;

endmodule

/* hdl/per_sender_token_bucket.sv */
// Channel     Dir  Handshake                 Payload (low bit first)
// s_axis      in   tvalid/tready             sender_id[63:0], now_ms[95:64], cost[111:96]
// m_axis      out  tvalid/tready             allowed[0], tokens_left[24:1], new_entry[25]
// APB config  in   psel/penable/pwrite/pready refill_rate @0x0, burst_cap @0x4
//
// One request at a time. The table walk reads one slot per cycle from the
// slot RAM. A hit with no elapsed time skips the refill; a refill first
// multiplies rate*elapsed, then divides by 1000 with a shift by 3 and a
// reciprocal multiply by 1/125. Reset clears the fill count, the control
// state and the configuration registers; the RAM is not cleared, since
// only slots below the fill count are ever read. The input is taken again
// while a result still waits in the output register; a stalled output
// holds the block only at its final write-back.
module per_sender_token_bucket #(
  parameter int unsigned SLOT_COUNT = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sender_id [63:0], now_ms [95:64], cost [111:96]
  input  logic [pstb_pkg::InW-1:0]      s_axis_tdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // allowed [0], tokens_left [24:1], new_entry [25], zero above
  output logic [pstb_pkg::OutW-1:0]     m_axis_tdata_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pstb_pkg::CfgAddrW-1:0] paddr,
  input  logic [pstb_pkg::CfgDataW-1:0] pwdata,
  output logic [pstb_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);
  import pstb_pkg::*;

  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CntW = $clog2(SLOT_COUNT + 1);
  localparam logic [CntW-1:0] SlotMax = CntW'(SLOT_COUNT);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StScan   = 3'd1;
  localparam logic [2:0] StElapse = 3'd2;
  localparam logic [2:0] StMul    = 3'd3;
  localparam logic [2:0] StWait   = 3'd4;
  localparam logic [2:0] StCap    = 3'd5;
  localparam logic [2:0] StDone   = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [CntW-1:0]  issue_q, issue_d;
  logic             pend_q, pend_d;
  logic [IdxW-1:0]  pend_idx_q, pend_idx_d;
  logic [TimeW-1:0] oldest_q, oldest_d;
  logic [IdxW-1:0]  victim_q, victim_d;
  logic [IdxW-1:0]  slot_q, slot_d;
  logic             fresh_q, fresh_d;
  logic [TokW-1:0]  tok_q, tok_d;
  logic [TimeW-1:0] last_q, last_d;
  logic [TimeW-1:0] elapsed_q, elapsed_d;
  logic [KeyW-1:0]  key_q, key_d;
  logic [TimeW-1:0] now_q, now_d;
  logic [CostW-1:0] cost_q, cost_d;
  logic             out_valid_q, out_valid_d;
  logic [OutW-1:0]  out_data_q, out_data_d;
  logic [RateW-1:0] rate_q, rate_d;
  logic [TokW-1:0]  burst_q, burst_d;

  logic             in_fire;
  logic             cfg_wr;
  logic             ram_we;
  logic [EntW-1:0]  ram_wdata;
  logic [EntW-1:0]  ram_rdata;
  logic [KeyW-1:0]  rd_key;
  logic [TokW-1:0]  rd_tok;
  logic [TimeW-1:0] rd_last;
  logic             allow;
  logic [TokW-1:0]  tok_left;
  logic [TokW:0]    refill_sum;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == StIdle);

  assign {rd_last, rd_tok, rd_key} = ram_rdata;

  // cost decision on the bucket after any refill; a denial empties it
  assign allow    = (tok_q >= TokW'(cost_q));
  assign tok_left = allow ? (tok_q - TokW'(cost_q)) : '0;
  assign refill_sum = {1'b0, tok_q} + {1'b0, div_rsp.gain[TokW-1:0]};

  assign ram_wdata = {now_q, tok_left, key_q};

  assign div_req.start   = (state_q == StMul) && (elapsed_q != '0);
  assign div_req.rate    = rate_q;
  assign div_req.elapsed = elapsed_q;

  pstb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  pstb_ram #(
    .Width (EntW),
    .Depth (SLOT_COUNT)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (ram_wdata),
    .raddr_i (issue_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    issue_d     = issue_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    oldest_d    = oldest_q;
    victim_d    = victim_q;
    slot_d      = slot_q;
    fresh_d     = fresh_q;
    tok_d       = tok_q;
    last_d      = last_q;
    elapsed_d   = elapsed_q;
    key_d       = key_q;
    now_d       = now_q;
    cost_d      = cost_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;

    // drain the output register
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          key_d    = s_axis_tdata_i[KeyW-1:0];
          now_d    = s_axis_tdata_i[KeyW+TimeW-1:KeyW];
          cost_d   = s_axis_tdata_i[InW-1:KeyW+TimeW];
          issue_d  = '0;
          pend_d   = 1'b0;
          oldest_d = '1;
          victim_d = '0;
          state_d  = StScan;
        end
      end
      StScan: begin
        if (pend_q && (rd_key == key_q)) begin
          // hit: take this slot's bucket
          slot_d  = pend_idx_q;
          tok_d   = rd_tok;
          last_d  = rd_last;
          fresh_d = 1'b0;
          state_d = StElapse;
        end else begin
          // track the oldest slot, strict compare keeps the lowest index on ties
          if (pend_q && (rd_last < oldest_q)) begin
            oldest_d = rd_last;
            victim_d = pend_idx_q;
          end
          if (issue_q < fill_q) begin
            pend_d     = 1'b1;
            pend_idx_d = issue_q[IdxW-1:0];
            issue_d    = issue_q + CntW'(1);
          end else begin
            pend_d = 1'b0;
            if (!pend_q) begin
              // miss: claim the next free slot, or replace the oldest
              slot_d  = (fill_q < SlotMax) ? fill_q[IdxW-1:0] : victim_q;
              tok_d   = burst_q;
              last_d  = now_q;
              fresh_d = 1'b1;
              state_d = StDone;
            end
          end
        end
      end
      StElapse: begin
        elapsed_d = now_q - last_q;
        state_d   = StMul;
      end
      StMul: begin
        // no time gone by: bucket left as is, not even capped
        state_d = (elapsed_q == '0) ? StDone : StWait;
      end
      StWait: begin
        if (div_rsp.done) begin
          state_d = StCap;
        end
      end
      StCap: begin
        if (div_rsp.gain[ProdW-1:TokW] != '0) begin
          tok_d = burst_q;
        end else if (refill_sum > {1'b0, burst_q}) begin
          tok_d = burst_q;
        end else begin
          tok_d = refill_sum[TokW-1:0];
        end
        state_d = StDone;
      end
      StDone: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready_i) begin
          ram_we      = 1'b1;
          out_valid_d = 1'b1;
          out_data_d  = {{(OutW-TokW-2){1'b0}}, fresh_q, tok_left, allow};
          if (fresh_q && (fill_q < SlotMax)) begin
            fill_d = fill_q + CntW'(1);
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // configuration writes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    rate_d  = rate_q;
    burst_d = burst_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        RegRefillRate: rate_d  = pwdata[RateW-1:0];
        RegBurstCap:   burst_d = pwdata[TokW-1:0];
        default:       rate_d  = rate_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegRefillRate: prdata = CfgDataW'(rate_q);
      RegBurstCap:   prdata = CfgDataW'(burst_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fill_q      <= '0;
      issue_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      rate_q      <= RefillRateRst;
      burst_q     <= BurstCapRst;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      rate_q      <= rate_d;
      burst_q     <= burst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    oldest_q   <= oldest_d;
    victim_q   <= victim_d;
    slot_q     <= slot_d;
    fresh_q    <= fresh_d;
    tok_q      <= tok_d;
    last_q     <= last_d;
    elapsed_q  <= elapsed_d;
    key_q      <= key_d;
    now_q      <= now_d;
    cost_q     <= cost_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
